@@ rtl/core/rtdal_pkg.sv @@
// rtdal_pkg: shared widths, constants, codes and types for the rtd averager
// and linearising block. No dependencies; imported by every rtl/core module.

package rtdal_pkg;

	// stream payload widths
	localparam int IDX_W      = 2;
	localparam int CODE_W     = 16;
	localparam int FLAG_W     = 8;
	localparam int TEMP_W     = 20;
	localparam int STAT_W     = 2;
	localparam int IN_W       = 32;
	localparam int OUT_W      = 48;

	// accumulator
	localparam int SUM_W      = 20;
	localparam int CNT_W      = 4;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MODE_W     = 2;

	// serial divider
	localparam int DIV_NUM_W  = 56;
	localparam int DIV_DEN_W  = 25;
	localparam int DIV_LEN_W  = 6;

	// serial square root
	localparam int SQ_RAD_W   = 56;
	localparam int SQ_ROOT_W  = 28;
	localparam int SQ_REM_W   = SQ_ROOT_W + 2;
	localparam int SQ_STEPS   = SQ_RAD_W / 2;
	localparam int SQ_CNT_W   = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIRE_EN  = 2'd3;

	// reference modes and matching break flags
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOW  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HIGH = 2'd2;
	localparam logic [FLAG_W-1:0] BREAK_LOW  = 8'h01;
	localparam logic [FLAG_W-1:0] BREAK_HIGH = 8'h03;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BREAK = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	// code at 100 ohms and full-scale code
	localparam logic [CODE_W-1:0] R0_CODE   = 16'd13107;
	localparam logic [18:0]       FULL_CODE = 19'd65535;

	// above 100 ohms: n = d * 23100000000 = (d * 90234375) << 8
	localparam logic [26:0] MUL_HI = 27'd90234375;
	// below 100 ohms: m = (13107 - avg) * 128000000, plus half divisor
	localparam logic [26:0] MUL_LO = 27'd128000000;
	localparam logic [DIV_NUM_W-1:0] LIN_BIAS = 56'd12615487;

	// constant divisors
	localparam logic [DIV_DEN_W-1:0] DEN_FULL  = 25'd65535;
	localparam logic [DIV_DEN_W-1:0] DEN_TWO_B = 25'd231;
	localparam logic [DIV_DEN_W-1:0] DEN_LIN   = 25'd25230975;

	// quotient bit counts per division
	localparam logic [DIV_LEN_W-1:0] LEN_AVG = 6'd20;
	localparam logic [DIV_LEN_W-1:0] LEN_N   = 6'd54;
	localparam logic [DIV_LEN_W-1:0] LEN_THI = 6'd28;
	localparam logic [DIV_LEN_W-1:0] LEN_TLO = 6'd42;

	// A^2 term scaled by 2^16, A term scaled by 256, rounding for 2B
	localparam logic [DIV_NUM_W-1:0] RAD_TOP = 56'd152748088900 << 16;
	localparam logic [SQ_ROOT_W-1:0] A_TOP   = 28'd100052480;
	localparam logic [SQ_ROOT_W:0]   ROUND_TWO_B = 29'd115;

	// sequencer states
	typedef enum logic [2:0] {
		ST_ACC,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_PREP,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_FIN
	} state_t;

	// which division is in flight
	typedef enum logic [1:0] {
		PH_AVG,
		PH_NDIV,
		PH_THI,
		PH_TLO
	} phase_t;

	// divider control from the sequencer
	typedef struct packed {
		logic                 start;
		logic [DIV_LEN_W-1:0] len;
	} div_ctl_t;

endpackage

@@ rtl/core/rtdal_div.sv @@
// rtdal_div: restoring divider, one quotient bit per cycle, msb first.
// Depends on rtdal_pkg for widths and the div_ctl_t control struct.

module rtdal_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rtdal_pkg::div_ctl_t             ctl,
	input  logic [rtdal_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [rtdal_pkg::DIV_DEN_W-1:0] divisor,
	output logic                            done,
	output logic [rtdal_pkg::DIV_NUM_W-1:0] quotient
);
	import rtdal_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_LEN_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;

	logic [DIV_LEN_W-1:0] bit_idx;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   trial_sub;
	logic                 take;

	// bring down the next dividend bit and try the subtraction
	always_comb begin
		bit_idx   = cnt_q - DIV_LEN_W'(1);
		trial     = {rem_q, num_q[bit_idx]};
		trial_sub = trial - {1'b0, den_q};
		take      = trial >= {1'b0, den_q};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_LEN_W'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_LEN_W'(1);
				if (cnt_q == DIV_LEN_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/core/rtdal_isqrt.sv @@
// rtdal_isqrt: digit-by-digit integer square root, two radicand bits a cycle.
// Depends on rtdal_pkg for widths.

module rtdal_isqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rtdal_pkg::SQ_RAD_W-1:0]  radicand,
	output logic                            done,
	output logic [rtdal_pkg::SQ_ROOT_W-1:0] root
);
	import rtdal_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [SQ_CNT_W-1:0]  cnt_q;
	logic [SQ_RAD_W-1:0]  rad_q;
	logic [SQ_REM_W-1:0]  rem_q;
	logic [SQ_ROOT_W-1:0] root_q;

	logic [SQ_REM_W+1:0]  cur;
	logic [SQ_REM_W+1:0]  trial;
	logic [SQ_REM_W+1:0]  cur_sub;
	logic                 take;

	// shift in the next bit pair and test root*4+1
	always_comb begin
		cur     = {rem_q, rad_q[SQ_RAD_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		cur_sub = cur - trial;
		take    = cur >= trial;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == SQ_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CNT_W'(SQ_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - SQ_CNT_W'(1);
				if (cnt_q == SQ_CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// radicand, remainder and root shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_RAD_W-3:0], 2'b00};
			rem_q  <= take ? cur_sub[SQ_REM_W-1:0] : cur[SQ_REM_W-1:0];
			root_q <= {root_q[SQ_ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/core/rtd_average_and_linearize.sv @@
// rtd_average_and_linearize: burst averager and rtd linearising top level.
// After the last request of a burst the average is divided out; then at or
// above 100 ohms a division, a square root and a division follow, below
// 100 ohms one division; the result then waits for the output register to empty.
// Throughput: one request a cycle inside a burst; s_tready is low from the
// last request of a burst until the result is loaded. Async reset clears.
// Depends on rtdal_pkg, rtdal_div and rtdal_isqrt.

module rtd_average_and_linearize #(
	parameter int SAMPLES = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_tdata: adc_index, channel_index, raw_sample, wire_status (lsb up)
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rtdal_pkg::IN_W-1:0]       s_tdata,
	// m_tdata: adc_index_out, channel_index_out, average_code, temperature_q8
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rtdal_pkg::OUT_W-1:0]      m_tdata,
	// m_tuser: status
	output logic [rtdal_pkg::STAT_W-1:0]     m_tuser,
	input  logic                             cfg_wr_en,
	input  logic [rtdal_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
	input  logic [rtdal_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
	import rtdal_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
	localparam logic [DIV_DEN_W-1:0] DEN_AVG = DIV_DEN_W'(SAMPLES);

	// configuration
	logic [CODE_W-1:0] min_code_q;
	logic [CODE_W-1:0] max_code_q;
	logic [MODE_W-1:0] ref_mode_q;
	logic              wire_en_q;

	// control
	state_t            state_q, state_d;
	phase_t            phase_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              m_tvalid_q;

	// datapath
	logic [DIV_NUM_W-1:0] work_q;
	logic [CODE_W-1:0]    avg_q;
	logic [TEMP_W-1:0]    temp_q;
	logic [IDX_W-1:0]     adc_q;
	logic [IDX_W-1:0]     ch_q;
	logic [FLAG_W-1:0]    flag_q;

	// result register
	logic [IDX_W-1:0]  adc_out_q;
	logic [IDX_W-1:0]  ch_out_q;
	logic [CODE_W-1:0] code_out_q;
	logic [TEMP_W-1:0] temp_out_q;
	logic [STAT_W-1:0] stat_out_q;

	// unpacked request
	logic [IDX_W-1:0]  in_adc;
	logic [IDX_W-1:0]  in_ch;
	logic [CODE_W-1:0] in_raw;
	logic [FLAG_W-1:0] in_flag;
	logic [CODE_W-1:0] in_word;
	logic [SUM_W-1:0]  sum_next;
	logic              in_take;
	logic              in_last;

	// unit interfaces
	div_ctl_t             div_ctl;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic                 sq_start;
	logic                 sq_done;
	logic [SQ_ROOT_W-1:0] sq_root;
	logic                 out_load;

	// arithmetic between the serial steps
	logic                 hi_range;
	logic [18:0]          five_avg;
	logic [17:0]          d_val;
	logic [13:0]          e_val;
	logic [17:0]          mul_a;
	logic [26:0]          mul_b;
	logic [44:0]          prod;
	logic [DIV_NUM_W-1:0] prep_val;
	logic [DIV_NUM_W-1:0] rad_val;
	logic [SQ_ROOT_W-1:0] a_diff;
	logic [SQ_ROOT_W:0]   t_num;
	logic                 open_wire;
	logic                 out_window;
	logic [STAT_W-1:0]    stat_val;

	// request fields, bytes swapped back
	always_comb begin
		in_adc   = s_tdata[1:0];
		in_ch    = s_tdata[3:2];
		in_raw   = s_tdata[19:4];
		in_flag  = s_tdata[27:20];
		in_word  = {in_raw[7:0], in_raw[15:8]};
		sum_next = sum_q + {{(SUM_W-CODE_W){1'b0}}, in_word};
		in_take  = s_tvalid && s_tready;
		in_last  = cnt_q == CNT_LAST;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_q <= '0;
			max_code_q <= '1;
			ref_mode_q <= MODE_HIGH;
			wire_en_q  <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_wr_index)
				REG_MIN_CODE: min_code_q <= cfg_wr_data;
				REG_MAX_CODE: max_code_q <= cfg_wr_data;
				REG_REF_MODE: ref_mode_q <= cfg_wr_data[MODE_W-1:0];
				REG_WIRE_EN:  wire_en_q  <= cfg_wr_data[0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC: begin
				if (in_take && in_last)
					state_d = ST_DIV_GO;
			end
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					case (phase_q)
						PH_AVG:  state_d = ST_PREP;
						PH_NDIV: state_d = ST_SQRT_GO;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_PREP: state_d = ST_DIV_GO;
			ST_SQRT_GO: state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: begin
				if (sq_done)
					state_d = ST_DIV_GO;
			end
			ST_FIN: begin
				if (out_load)
					state_d = ST_ACC;
			end
			default: state_d = ST_ACC;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready      = state_q == ST_ACC;
		div_ctl.start = state_q == ST_DIV_GO;
		sq_start      = state_q == ST_SQRT_GO;
		out_load      = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
		case (phase_q)
			PH_AVG: begin
				div_ctl.len = LEN_AVG;
				div_den     = DEN_AVG;
			end
			PH_NDIV: begin
				div_ctl.len = LEN_N;
				div_den     = DEN_FULL;
			end
			PH_THI: begin
				div_ctl.len = LEN_THI;
				div_den     = DEN_TWO_B;
			end
			default: begin
				div_ctl.len = LEN_TLO;
				div_den     = DEN_LIN;
			end
		endcase
	end

	// branch setup: one shared constant multiply
	always_comb begin
		hi_range = avg_q >= R0_CODE;
		five_avg = {1'b0, avg_q, 2'b00} + {3'b000, avg_q};
		d_val    = 18'(five_avg - FULL_CODE);
		e_val    = 14'(R0_CODE - avg_q);
		mul_a    = hi_range ? d_val : {4'b0000, e_val};
		mul_b    = hi_range ? MUL_HI : MUL_LO;
		prod     = {27'd0, mul_a} * {18'd0, mul_b};
		if (hi_range)
			prep_val = {3'b000, prod, 8'd0};
		else
			prep_val = {11'd0, prod} + LIN_BIAS;
	end

	// radicand, and the numerator over 2B
	always_comb begin
		rad_val = RAD_TOP - work_q - div_quo;
		a_diff  = A_TOP - sq_root;
		t_num   = {a_diff, 1'b0} + ROUND_TWO_B;
	end

	// wire and window checks; wire break wins
	always_comb begin
		open_wire = ((ref_mode_q == MODE_LOW) && (flag_q == BREAK_LOW)) ||
			((ref_mode_q == MODE_HIGH) && (flag_q == BREAK_HIGH));
		out_window = (avg_q < min_code_q) || (avg_q > max_code_q);
		if (!wire_en_q)
			stat_val = STAT_OK;
		else if (open_wire)
			stat_val = STAT_BREAK;
		else if (out_window)
			stat_val = STAT_RANGE;
		else
			stat_val = STAT_OK;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACC;
			phase_q    <= PH_AVG;
			sum_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				if (in_last) begin
					sum_q   <= '0;
					cnt_q   <= '0;
					phase_q <= PH_AVG;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (state_q == ST_PREP)
				phase_q <= hi_range ? PH_NDIV : PH_TLO;
			if ((state_q == ST_SQRT_WAIT) && sq_done)
				phase_q <= PH_THI;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_take && in_last) begin
			work_q <= {{(DIV_NUM_W-SUM_W){1'b0}}, sum_next};
			adc_q  <= in_adc;
			ch_q   <= in_ch;
			flag_q <= in_flag;
		end
		if (state_q == ST_PREP)
			work_q <= prep_val;
		if ((state_q == ST_SQRT_WAIT) && sq_done)
			work_q <= {{(DIV_NUM_W-SQ_ROOT_W-1){1'b0}}, t_num};
		if ((state_q == ST_DIV_WAIT) && div_done) begin
			case (phase_q)
				PH_AVG:  avg_q  <= div_quo[CODE_W-1:0];
				PH_NDIV: work_q <= rad_val;
				PH_THI:  temp_q <= div_quo[TEMP_W-1:0];
				default: temp_q <= TEMP_W'(0) - div_quo[TEMP_W-1:0];
			endcase
		end
	end

	// result register, faults force code and temperature to zero
	always_ff @(posedge clk) begin
		if (out_load) begin
			adc_out_q  <= adc_q;
			ch_out_q   <= ch_q;
			code_out_q <= (stat_val == STAT_OK) ? avg_q : '0;
			temp_out_q <= (stat_val == STAT_OK) ? temp_q : '0;
			stat_out_q <= stat_val;
		end
	end

	rtdal_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (work_q),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	rtdal_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (work_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {8'd0, temp_out_q, code_out_q, ch_out_q, adc_out_q};
	assign m_tuser  = stat_out_q;

endmodule

@@ rtl/core/rtdal_chk.sv @@
// rtdal_chk: port-level checks on the rtd averager top level, bound to it.
// Depends on rtdal_pkg and rtd_average_and_linearize.

module rtdal_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [rtdal_pkg::OUT_W-1:0]  m_tdata,
	input logic [rtdal_pkg::STAT_W-1:0] m_tuser
);
	import rtdal_pkg::*;

	logic [CODE_W-1:0] code_f;
	logic [TEMP_W-1:0] temp_f;

	assign code_f = m_tdata[19:4];
	assign temp_f = m_tdata[39:20];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a fault result carries zero code and temperature
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_OK) |-> (code_f == '0) && (temp_f == '0))
		else $error("fault result not zeroed");

	// good result: sign of temperature follows the 100 ohm split
	a_branch_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_OK) |-> ((code_f >= R0_CODE) == !temp_f[TEMP_W-1]))
		else $error("temperature sign does not match branch");

	// a new result only follows a busy period with requests blocked
	a_new_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while requests were open");

	// no input taken while the result of the same burst is being worked out
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("request taken in the cycle before a new result");

endmodule

bind rtd_average_and_linearize rtdal_chk u_chk (.*);

@@ tb/sv/rtd_average_and_linearize_tb.sv @@
// rtd_average_and_linearize_tb: self-checking bench for the rtd burst averager
// and linearising block; a scoreboard class predicts each burst result.
// Depends on rtdal_pkg and the rtd_average_and_linearize rtl.
`timescale 1ns / 1ps

module rtd_average_and_linearize_tb;
	import rtdal_pkg::*;

	localparam int BURST_LEN = 10;
	localparam int PHASES = 8;
	localparam int BURSTS_PER_PHASE = 7;
	localparam int SETTLE_CYCLES = 160;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AT_RESULT = 20;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	// one expected burst result
	typedef struct {
		logic [IDX_W-1:0]         adc;
		logic [IDX_W-1:0]         chan;
		logic [CODE_W-1:0]        code;
		logic signed [TEMP_W-1:0] temp_q8;
		logic [STAT_W-1:0]        status;
	} burst_result_t;

	// burst accumulator, linearisation and fault checks, plus pending results
	class rtd_burst_scoreboard;
		logic [CODE_W-1:0] min_code;
		logic [CODE_W-1:0] max_code;
		logic [MODE_W-1:0] ref_mode;
		logic              wire_en;
		logic [SUM_W-1:0]  burst_sum;
		logic [CNT_W-1:0]  burst_count;
		burst_result_t     expected_bursts[$];
		int                error_count;

		function new();
			min_code = '0;
			max_code = '1;
			ref_mode = MODE_HIGH;
			wire_en = 1'b1;
			burst_sum = '0;
			burst_count = '0;
			error_count = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MIN_CODE: min_code = data;
				REG_MAX_CODE: max_code = data;
				REG_REF_MODE: ref_mode = data[MODE_W-1:0];
				REG_WIRE_EN: wire_en = data[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_bursts.size();
		endfunction

		// accepted sample: swap bytes, accumulate, predict at the end of a burst
		function void note_sample(logic [IDX_W-1:0] adc, logic [IDX_W-1:0] chan,
			logic [CODE_W-1:0] raw, logic [FLAG_W-1:0] flag);
			logic [CODE_W-1:0] avg;
			logic [63:0]       d, n, rad, rem, root, b, diff, m;
			longint            t;
			logic              brk;
			burst_result_t     r;
			burst_sum = burst_sum + SUM_W'({raw[7:0], raw[15:8]});
			burst_count = burst_count + CNT_W'(1);
			if (int'(burst_count) < BURST_LEN)
				return;
			avg = CODE_W'(burst_sum / SUM_W'(BURST_LEN));
			if (avg >= R0_CODE) begin
				// inverse callendar-van dusen root, all scaled to integers
				d = 64'd5 * 64'(avg) - 64'd65535;
				n = 64'd23100000000 * d;
				rad = 64'd152748088900 * 64'd65536 - (n + n / 64'd65535);
				rem = rad;
				root = '0;
				b = 64'h1 << 62;
				while (b > rem)
					b = b >> 2;
				while (b != 0) begin
					if (rem >= root + b) begin
						rem = rem - (root + b);
						root = (root >> 1) + b;
					end else begin
						root = root >> 1;
					end
					b = b >> 2;
				end
				diff = 64'd390830 * 64'd256 - root;
				t = longint'((64'd2 * diff + 64'd115) / 64'd231);
			end else begin
				// linear slope below 100 ohms
				m = (64'd6553500 - 64'd500 * 64'(avg)) * 64'd256000;
				t = -longint'((m + 64'd12615487) / 64'd25230975);
			end
			brk = (ref_mode == MODE_LOW && flag == BREAK_LOW) ||
				(ref_mode == MODE_HIGH && flag == BREAK_HIGH);
			r.status = STAT_OK;
			if (wire_en) begin
				if (brk)
					r.status = STAT_BREAK;
				else if (avg < min_code || avg > max_code)
					r.status = STAT_RANGE;
			end
			r.adc = adc;
			r.chan = chan;
			r.code = (r.status == STAT_OK) ? avg : '0;
			r.temp_q8 = (r.status == STAT_OK) ? t[TEMP_W-1:0] : '0;
			expected_bursts.push_back(r);
			burst_sum = '0;
			burst_count = '0;
		endfunction

		// accepted result against the oldest prediction
		function void check_burst_result(logic [OUT_W-1:0] data, logic [STAT_W-1:0] user);
			burst_result_t e;
			if (expected_bursts.size() == 0) begin
				$error("unexpected result: data %h status %0d", data, user);
				error_count++;
				return;
			end
			e = expected_bursts.pop_front();
			if (data[1:0] !== e.adc) begin
				$error("adc_index_out: expected %0d got %0d", e.adc, data[1:0]);
				error_count++;
			end
			if (data[3:2] !== e.chan) begin
				$error("channel_index_out: expected %0d got %0d", e.chan, data[3:2]);
				error_count++;
			end
			if (data[19:4] !== e.code) begin
				$error("average_code: expected %0d got %0d", e.code, data[19:4]);
				error_count++;
			end
			if (data[39:20] !== e.temp_q8) begin
				$error("temperature_q8: expected %0d got %0d", e.temp_q8,
					$signed(data[39:20]));
				error_count++;
			end
			if (user !== e.status) begin
				$error("status: expected %0d got %0d", e.status, user);
				error_count++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic [STAT_W-1:0]     m_tuser;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_wr_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;

	rtd_burst_scoreboard sb = new();
	bit                  burst_no_gaps;
	int                  results_seen;

	rtd_average_and_linearize #(
		.SAMPLES(BURST_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_index(cfg_wr_index),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one sample request, with a random gap unless the burst runs back to back
	task automatic send_sample(logic [IDX_W-1:0] adc, logic [IDX_W-1:0] chan,
		logic [CODE_W-1:0] raw, logic [FLAG_W-1:0] flag);
		int gap;
		gap = burst_no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {4'b0, flag, raw, chan, adc};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_sample(adc, chan, raw, flag);
	endtask

	// one random burst of words, byte-swapped as the converter sends them
	task automatic send_burst();
		logic [CODE_W-1:0] specials[6] = '{16'd0, 16'd65535, 16'd13106, 16'd13107,
			16'd1, 16'd65534};
		logic [CODE_W-1:0] base, word;
		logic [FLAG_W-1:0] flag;
		int                kind;
		burst_no_gaps = ($urandom_range(0, 3) == 0);
		kind = $urandom_range(0, 2);
		base = (kind == 0) ? specials[3'($urandom_range(0, 5))] :
			CODE_W'($urandom_range(0, 65535));
		for (int k = 0; k < BURST_LEN; k++) begin
			case (kind)
				0: word = base;
				1: word = (base > 16'd65280) ? base : base + CODE_W'($urandom_range(0, 255));
				default: word = CODE_W'($urandom_range(0, 65535));
			endcase
			flag = FLAG_W'($urandom_range(0, 255));
			if (k == BURST_LEN - 1) begin
				case ($urandom_range(0, 3))
					0: flag = 8'h00;
					1: flag = BREAK_LOW;
					2: flag = BREAK_HIGH;
					default: ;
				endcase
			end
			send_sample(IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
				{word[7:0], word[15:8]}, flag);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_wr_index <= idx;
		cfg_wr_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// drain all results, let the pipeline settle, then rewrite every register
	task automatic reconfigure(logic [CODE_W-1:0] lo, logic [CODE_W-1:0] hi,
		logic [MODE_W-1:0] mode, logic en);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_MIN_CODE, lo);
		write_reg(REG_MAX_CODE, hi);
		write_reg(REG_REF_MODE, {14'($urandom_range(0, 16383)), mode});
		write_reg(REG_WIRE_EN, {15'($urandom_range(0, 32767)), en});
		cfg_wr_en <= 1'b0;
	endtask

	// result side: random stalls, stretches with none, one long hold-off
	initial begin
		int  stall;
		bit  no_stalls;
		bit  held_off;
		m_tready <= 1'b0;
		results_seen = 0;
		held_off = 0;
		no_stalls = 0;
		@(posedge arst_n);
		forever begin
			if (results_seen % 8 == 0)
				no_stalls = ($urandom_range(0, 2) == 0);
			stall = no_stalls ? 0 : $urandom_range(0, 9);
			if (results_seen == HOLD_AT_RESULT && !held_off) begin
				stall = HOLD_CYCLES;
				held_off = 1;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			sb.check_burst_result(m_tdata, m_tuser);
			results_seen++;
		end
	end

	// stimulus
	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_index <= REG_MIN_CODE;
		cfg_wr_data <= '0;
		burst_no_gaps = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale and zero words mixed, indices mixed, break flag at the end
		for (int k = 0; k < BURST_LEN; k++)
			send_sample(IDX_W'(k % 3), IDX_W'(3 - k % 4), k[0] ? 16'hFFFF : 16'h0000,
				(k == BURST_LEN - 1) ? BREAK_HIGH : 8'hFF);
		// exactly 100 ohms, low-mode break flag that is not a break here
		burst_no_gaps = 1;
		for (int k = 0; k < BURST_LEN; k++)
			send_sample(2'd3, 2'd3, 16'h3333, (k == BURST_LEN - 1) ? BREAK_LOW : 8'h00);

		for (int p = 1; p <= PHASES; p++) begin
			case (p)
				1: reconfigure(16'd13000, 16'd40000, MODE_LOW, 1'b1);
				2: reconfigure(16'd65535, 16'd0, MODE_SPARE, 1'b1);
				3: reconfigure(16'd30000, 16'd31000, MODE_HIGH, 1'b0);
				4: reconfigure(16'd0, 16'd65535, MODE_NONE, 1'b1);
				default: begin
					if ($urandom_range(0, 3) == 0)
						reconfigure(CODE_W'($urandom_range(0, 65535)),
							CODE_W'($urandom_range(0, 65535)),
							MODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
					else
						reconfigure(CODE_W'($urandom_range(0, 20000)),
							CODE_W'($urandom_range(30000, 65535)),
							MODE_W'($urandom_range(0, 3)), ($urandom_range(0, 3) != 0));
				end
			endcase
			for (int b = 0; b < BURSTS_PER_PHASE; b++)
				send_burst();
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.error_count == 0)
			$display("rtd_average_and_linearize_tb: clean");
		else
			$display("rtd_average_and_linearize_tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("rtd_average_and_linearize_tb: errors");
		$finish;
	end

endmodule

@@ rtd_average_and_linearize.f @@
rtl/core/rtdal_pkg.sv
rtl/core/rtdal_div.sv
rtl/core/rtdal_isqrt.sv
rtl/core/rtd_average_and_linearize.sv
rtl/core/rtdal_chk.sv
tb/sv/rtd_average_and_linearize_tb.sv
